/* rtl/simap_pkg.sv */
`timescale 1ns / 1ps
// Package: payload types, sequencer states and constants of the identity map swap block.
package simap_pkg;

    localparam int NUM_BUCKETS_DEF = 1024;
    localparam int MAX_ENTRIES_DEF = 1024;
    localparam logic [31:0] HASH_PRIME = 32'd1117809793;

    typedef struct packed {
        logic signed [31:0] key_a;
        logic signed [31:0] key_b;
    } simap_in_t;

    typedef struct packed {
        logic [31:0] abs_difference;
        logic        table_full;
    } simap_out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH1,
        ST_HASH2,
        ST_HASH3,
        ST_HASH4,
        ST_HASH5,
        ST_HEAD_RD,
        ST_HEAD_CHK,
        ST_ENT_RD,
        ST_ENT_CHK,
        ST_DECIDE,
        ST_INS_A,
        ST_INS_B,
        ST_SWAP_A,
        ST_SWAP_B
    } simap_state_t;

endpackage

/* rtl/sparse_identity_map_swap.sv */
`timescale 1ns / 1ps
// Top level: chained hash map with identity default, swaps the values of two keys.
//
//  channel | ports                     | payload
//  --------+---------------------------+----------------------------------
//  input   | s_valid s_ready s_data    | key_a, key_b
//  result  | m_valid m_ready m_data    | abs_difference, table_full
//
//  Each key: reduction mod the prime by repeated subtraction on a shared
//  compare/subtract unit, then the bucket in four steps (reciprocal multiply,
//  back-multiply, subtract, correct), the head read, a read per entry visited.
//  Then a decide step, an insert step per new key and two swap writes.
//  After reset the bucket head memory is cleared while s_ready is low.
//  The next item is taken once the previous result has been taken.
module sparse_identity_map_swap #(
    parameter int NUM_BUCKETS = simap_pkg::NUM_BUCKETS_DEF,
    parameter int MAX_ENTRIES = simap_pkg::MAX_ENTRIES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  simap_pkg::simap_in_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output simap_pkg::simap_out_t  m_data
);
    localparam int BW = NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1;
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int HW = IW + 1;
    localparam int EW = 64 + HW;
    localparam logic [31:0] NB32 = 32'(NUM_BUCKETS);
    localparam logic [BW-1:0] LAST_BKT = BW'(NUM_BUCKETS - 1);
    localparam logic [IW:0] MAX_CNT = (IW+1)'(MAX_ENTRIES);
    localparam logic [32:0] NEG_OFS =
        33'(64'hFFFF_FFFF_0000_0000 % {32'd0, simap_pkg::HASH_PRIME});
    localparam logic [31:0] RECIP = 32'(64'h8000_0000 / 64'(NUM_BUCKETS));

    simap_pkg::simap_state_t state_reg, state_next;
    logic [31:0]   key_a_reg, key_a_next, key_b_reg, key_b_next;
    logic [32:0]   rem_reg, rem_next;
    logic [63:0]   dvd_reg, dvd_next;
    logic [BW-1:0] bkt_a_reg, bkt_a_next, bkt_b_reg, bkt_b_next;
    logic [BW-1:0] clr_reg, clr_next;
    logic          phase_b_reg, phase_b_next;
    logic [HW-1:0] hd_a_reg, hd_a_next, hd_b_reg, hd_b_next;
    logic          found_a_reg, found_a_next, found_b_reg, found_b_next;
    logic [IW-1:0] slot_a_reg, slot_a_next, slot_b_reg, slot_b_next;
    logic [31:0]   val_a_reg, val_a_next, val_b_reg, val_b_next;
    logic [HW-1:0] lnk_a_reg, lnk_a_next, lnk_b_reg, lnk_b_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW:0]   count_reg, count_next;
    logic          m_valid_reg, m_valid_next;
    simap_pkg::simap_out_t m_data_reg, m_data_next;

    logic          head_we;
    logic [BW-1:0] head_waddr, head_raddr;
    logic [HW-1:0] head_wdata, head_rdata;
    logic          ent_we;
    logic [IW-1:0] ent_waddr;
    logic [EW-1:0] ent_wdata, ent_rdata;

    logic [31:0] target, ent_key, ent_val, hash_key, mul_a, mul_b;
    logic [32:0] divisor, rem_new, hash_init;
    logic [63:0] mul_p;
    logic        rem_ge;
    logic [HW-1:0] ent_lnk;
    logic        same_key, lk_done, lk_found;
    logic [1:0]  need;
    logic [IW:0] room;
    logic [32:0] diff;

    simap_ram #(.WIDTH(HW), .DEPTH(NUM_BUCKETS)) u_heads (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );

    simap_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_entries (
        .aclk(aclk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(cur_reg), .rdata(ent_rdata)
    );

    assign s_ready  = (state_reg == simap_pkg::ST_IDLE) && !m_valid_reg;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign same_key = key_a_reg == key_b_reg;
    assign target   = phase_b_reg ? key_b_reg : key_a_reg;
    assign head_raddr = phase_b_reg ? bkt_b_reg : bkt_a_reg;
    assign ent_key  = ent_rdata[EW-1 -: 32];
    assign ent_val  = ent_rdata[EW-33 -: 32];
    assign ent_lnk  = ent_rdata[HW-1:0];

    // negative keys start from (2^64 - 2^32) mod prime plus the unsigned key
    assign hash_key  = (state_reg == simap_pkg::ST_IDLE) ? s_data.key_a : key_b_reg;
    assign hash_init = hash_key[31] ? NEG_OFS + {1'b0, hash_key} : {1'b0, hash_key};

    // shared compare/subtract and multiply
    assign divisor = (state_reg == simap_pkg::ST_HASH5) ? {1'b0, NB32}
                                                        : {1'b0, simap_pkg::HASH_PRIME};
    assign rem_ge  = rem_reg >= divisor;
    assign rem_new = rem_ge ? rem_reg - divisor : rem_reg;
    assign mul_a   = (state_reg == simap_pkg::ST_HASH3) ? dvd_reg[62:31] : rem_reg[31:0];
    assign mul_b   = (state_reg == simap_pkg::ST_HASH3) ? NB32 : RECIP;
    assign mul_p   = mul_a * mul_b;

    assign need = {1'b0, !found_a_reg} + {1'b0, !same_key && !found_b_reg};
    assign room = MAX_CNT - count_reg;
    assign diff = {val_b_reg[31], val_b_reg} - {val_a_reg[31], val_a_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= simap_pkg::ST_CLEAR;
            clr_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            phase_b_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            phase_b_reg <= phase_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_a_reg   <= key_a_next;
        key_b_reg   <= key_b_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        bkt_a_reg   <= bkt_a_next;
        bkt_b_reg   <= bkt_b_next;
        hd_a_reg    <= hd_a_next;
        hd_b_reg    <= hd_b_next;
        found_a_reg <= found_a_next;
        found_b_reg <= found_b_next;
        slot_a_reg  <= slot_a_next;
        slot_b_reg  <= slot_b_next;
        val_a_reg   <= val_a_next;
        val_b_reg   <= val_b_next;
        lnk_a_reg   <= lnk_a_next;
        lnk_b_reg   <= lnk_b_next;
        cur_reg     <= cur_next;
        m_data_reg  <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        key_a_next   = key_a_reg;
        key_b_next   = key_b_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        bkt_a_next   = bkt_a_reg;
        bkt_b_next   = bkt_b_reg;
        clr_next     = clr_reg;
        phase_b_next = phase_b_reg;
        hd_a_next    = hd_a_reg;
        hd_b_next    = hd_b_reg;
        found_a_next = found_a_reg;
        found_b_next = found_b_reg;
        slot_a_next  = slot_a_reg;
        slot_b_next  = slot_b_reg;
        val_a_next   = val_a_reg;
        val_b_next   = val_b_reg;
        lnk_a_next   = lnk_a_reg;
        lnk_b_next   = lnk_b_reg;
        cur_next     = cur_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        head_we      = 1'b0;
        head_waddr   = clr_reg;
        head_wdata   = '0;
        ent_we       = 1'b0;
        ent_waddr    = slot_a_reg;
        ent_wdata    = {key_a_reg, val_b_reg, lnk_a_reg};
        lk_done      = 1'b0;
        lk_found     = 1'b0;

        case (state_reg)
            simap_pkg::ST_CLEAR: begin
                head_we  = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_BKT) begin
                    state_next = simap_pkg::ST_IDLE;
                end
            end
            simap_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    key_a_next   = s_data.key_a;
                    key_b_next   = s_data.key_b;
                    phase_b_next = 1'b0;
                    rem_next     = hash_init;
                    state_next   = simap_pkg::ST_HASH1;
                end
            end
            simap_pkg::ST_HASH1: begin
                if (rem_ge) begin
                    rem_next = rem_new;
                end else begin
                    state_next = simap_pkg::ST_HASH2;
                end
            end
            simap_pkg::ST_HASH2: begin
                dvd_next   = mul_p;
                state_next = simap_pkg::ST_HASH3;
            end
            simap_pkg::ST_HASH3: begin
                dvd_next   = mul_p;
                state_next = simap_pkg::ST_HASH4;
            end
            simap_pkg::ST_HASH4: begin
                rem_next   = rem_reg - dvd_reg[32:0];
                state_next = simap_pkg::ST_HASH5;
            end
            simap_pkg::ST_HASH5: begin
                if (phase_b_reg) begin
                    bkt_b_next = rem_new[BW-1:0];
                end else begin
                    bkt_a_next = rem_new[BW-1:0];
                end
                state_next = simap_pkg::ST_HEAD_RD;
            end
            simap_pkg::ST_HEAD_RD: begin
                state_next = simap_pkg::ST_HEAD_CHK;
            end
            simap_pkg::ST_HEAD_CHK: begin
                if (phase_b_reg) begin
                    hd_b_next = head_rdata;
                end else begin
                    hd_a_next = head_rdata;
                end
                if (head_rdata[HW-1]) begin
                    cur_next   = head_rdata[IW-1:0];
                    state_next = simap_pkg::ST_ENT_RD;
                end else begin
                    lk_done = 1'b1;
                end
            end
            simap_pkg::ST_ENT_RD: begin
                state_next = simap_pkg::ST_ENT_CHK;
            end
            simap_pkg::ST_ENT_CHK: begin
                if (ent_key == target) begin
                    lk_done  = 1'b1;
                    lk_found = 1'b1;
                end else if (ent_lnk[HW-1]) begin
                    cur_next   = ent_lnk[IW-1:0];
                    state_next = simap_pkg::ST_ENT_RD;
                end else begin
                    lk_done = 1'b1;
                end
            end
            simap_pkg::ST_DECIDE: begin
                if ({{(IW-1){1'b0}}, need} > room) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{abs_difference: '0, table_full: 1'b1};
                    state_next   = simap_pkg::ST_IDLE;
                end else if (!found_a_reg) begin
                    state_next = simap_pkg::ST_INS_A;
                end else if (same_key) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{abs_difference: '0, table_full: 1'b0};
                    state_next   = simap_pkg::ST_IDLE;
                end else if (!found_b_reg) begin
                    state_next = simap_pkg::ST_INS_B;
                end else begin
                    state_next = simap_pkg::ST_SWAP_A;
                end
            end
            simap_pkg::ST_INS_A: begin
                ent_we      = 1'b1;
                ent_waddr   = count_reg[IW-1:0];
                ent_wdata   = {key_a_reg, key_a_reg, hd_a_reg};
                head_we     = 1'b1;
                head_waddr  = bkt_a_reg;
                head_wdata  = {1'b1, count_reg[IW-1:0]};
                slot_a_next = count_reg[IW-1:0];
                val_a_next  = key_a_reg;
                lnk_a_next  = hd_a_reg;
                count_next  = count_reg + 1'b1;
                if (bkt_b_reg == bkt_a_reg) begin
                    hd_b_next = {1'b1, count_reg[IW-1:0]};
                end
                if (same_key) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{abs_difference: '0, table_full: 1'b0};
                    state_next   = simap_pkg::ST_IDLE;
                end else if (!found_b_reg) begin
                    state_next = simap_pkg::ST_INS_B;
                end else begin
                    state_next = simap_pkg::ST_SWAP_A;
                end
            end
            simap_pkg::ST_INS_B: begin
                ent_we      = 1'b1;
                ent_waddr   = count_reg[IW-1:0];
                ent_wdata   = {key_b_reg, key_b_reg, hd_b_reg};
                head_we     = 1'b1;
                head_waddr  = bkt_b_reg;
                head_wdata  = {1'b1, count_reg[IW-1:0]};
                slot_b_next = count_reg[IW-1:0];
                val_b_next  = key_b_reg;
                lnk_b_next  = hd_b_reg;
                count_next  = count_reg + 1'b1;
                state_next  = simap_pkg::ST_SWAP_A;
            end
            simap_pkg::ST_SWAP_A: begin
                ent_we     = 1'b1;
                state_next = simap_pkg::ST_SWAP_B;
            end
            simap_pkg::ST_SWAP_B: begin
                ent_we       = 1'b1;
                ent_waddr    = slot_b_reg;
                ent_wdata    = {key_b_reg, val_a_reg, lnk_b_reg};
                m_valid_next = 1'b1;
                m_data_next  = '{abs_difference: diff[32] ? 32'(-diff) : diff[31:0],
                                 table_full: 1'b0};
                state_next   = simap_pkg::ST_IDLE;
            end
            default: begin
                state_next = simap_pkg::ST_IDLE;
            end
        endcase

        if (lk_done) begin
            if (phase_b_reg) begin
                found_b_next = lk_found;
                slot_b_next  = cur_reg;
                val_b_next   = ent_val;
                lnk_b_next   = ent_lnk;
                state_next   = simap_pkg::ST_DECIDE;
            end else begin
                found_a_next = lk_found;
                slot_a_next  = cur_reg;
                val_a_next   = ent_val;
                lnk_a_next   = ent_lnk;
                if (same_key) begin
                    found_b_next = lk_found;
                    state_next   = simap_pkg::ST_DECIDE;
                end else begin
                    phase_b_next = 1'b1;
                    rem_next     = hash_init;
                    state_next   = simap_pkg::ST_HASH1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_ready_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("ready while a result is pending");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT) else $error("entry count past capacity");
    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.table_full) |-> (m_data.abs_difference == '0))
        else $error("full flag with nonzero difference");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("ready right after accept");
`endif
endmodule

/* rtl/simap_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module simap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* verif/sparse_identity_map_swap_tb.sv */
`timescale 1ns / 1ps
// Testbench: random and directed key-pair swaps checked against a scoreboard model of the map.
module sparse_identity_map_swap_tb;

    localparam int MAX_ENT    = simap_pkg::MAX_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_LEN   = 600;

    typedef struct {
        simap_pkg::simap_in_t data;
        int                   mode;
    } pend_item_t;

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  s_valid = 0;
    logic                  s_ready;
    simap_pkg::simap_in_t  s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 0;
    simap_pkg::simap_out_t m_data;

    pend_item_t            pend_q[$];
    simap_pkg::simap_out_t swap_exp_q[$];
    logic [31:0]           map_val[logic [31:0]];
    bit                    gen_keys[logic [31:0]];
    logic [31:0]           key_pool[$];
    int                    stored_cnt = 0;
    int                    idle_mode = 0;
    int                    accepted = 0;
    int                    hold_left = 0;
    bit                    hold_done = 0;
    int                    cycles = 0;
    int                    errors = 0;

    sparse_identity_map_swap DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #2 aclk = ~aclk;

    function automatic simap_pkg::simap_out_t predict_swap(simap_pkg::simap_in_t req);
        simap_pkg::simap_out_t r;
        logic [31:0]           ka, kb, va, vb;
        int                    need;
        longint                d;
        ka = req.key_a;
        kb = req.key_b;
        need = (map_val.exists(ka) ? 0 : 1) + ((ka == kb || map_val.exists(kb)) ? 0 : 1);
        r = '0;
        if (stored_cnt + need > MAX_ENT) begin
            r.table_full = 1'b1;
            return r;
        end
        if (!map_val.exists(ka)) map_val[ka] = ka;
        if (!map_val.exists(kb)) map_val[kb] = kb;
        stored_cnt += need;
        if (ka == kb) return r;
        va = map_val[ka];
        vb = map_val[kb];
        map_val[ka] = vb;
        map_val[kb] = va;
        d = longint'($signed(vb)) - longint'($signed(va));
        if (d < 0) d = -d;
        r.abs_difference = d[31:0];
        return r;
    endfunction

    function automatic logic [31:0] pool_key();
        if (key_pool.size() == 0) return 32'd0;
        return key_pool[$urandom_range(key_pool.size() - 1)];
    endfunction

    task automatic add_req(logic [31:0] ka, logic [31:0] kb, int mode);
        pend_item_t p;
        p.data.key_a = ka;
        p.data.key_b = kb;
        p.mode = mode;
        pend_q.push_back(p);
        key_pool.push_back(ka);
        key_pool.push_back(kb);
        gen_keys[ka] = 1'b1;
        gen_keys[kb] = 1'b1;
    endtask

    // driver
    always @(posedge aclk) begin
        pend_item_t nxt;
        bit         busy;
        cycles <= cycles + 1;
        if (!aresetn) begin
            s_valid <= 0;
        end else begin
            busy = s_valid && !s_ready;
            if (s_valid && s_ready) begin
                swap_exp_q.push_back(predict_swap(s_data));
                accepted <= accepted + 1;
            end
            if (!busy) begin
                if (pend_q.size() > 0 &&
                    !((idle_mode == 1 && $urandom_range(99) < 63) ||
                      (idle_mode == 3 && $urandom_range(99) < 34))) begin
                    nxt = pend_q.pop_front();
                    idle_mode <= nxt.mode;
                    s_data <= nxt.data;
                    s_valid <= 1;
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    // long receiver hold
    always @(posedge aclk) begin
        if (!hold_done && accepted == 150) begin
            hold_done <= 1;
            hold_left <= HOLD_LEN;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        simap_pkg::simap_out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (swap_exp_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                errors++;
            end else begin
                exp_r = swap_exp_q.pop_front();
                if (m_data.abs_difference !== exp_r.abs_difference) begin
                    $display("%0t: abs_difference expected %h actual %h", $time,
                             exp_r.abs_difference, m_data.abs_difference);
                    errors++;
                end
                if (m_data.table_full !== exp_r.table_full) begin
                    $display("%0t: table_full expected %b actual %b", $time,
                             exp_r.table_full, m_data.table_full);
                    errors++;
                end
            end
        end
        if (hold_left > 0) begin
            m_ready <= 0;
        end else begin
            m_ready <= !((idle_mode == 2 && $urandom_range(99) < 63) ||
                         (idle_mode == 3 && $urandom_range(99) < 34));
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL sparse_identity_map_swap");
            $finish;
        end
    end

    initial begin
        logic [31:0] ka, kb;
        int          sel, mode, fill_i;
        add_req(32'd0, 32'd0, 0);
        add_req(32'h8000_0000, 32'h7fff_ffff, 0);
        add_req(32'h7fff_ffff, 32'h8000_0000, 0);
        add_req(32'hffff_ffff, 32'd1, 0);
        add_req(32'd5, 32'd5, 0);
        add_req(32'd5, 32'd5, 0);
        add_req(32'd5, 32'd7, 0);
        add_req(32'd3, 32'd1027, 0);
        add_req(32'd2051, 32'd3, 0);
        add_req(32'd1027, 32'd2051, 0);
        add_req(32'hffff_fc00, 32'h8000_0000, 0);
        add_req(32'h5555_5555, 32'haaaa_aaaa, 0);
        add_req(32'haaaa_aaaa, 32'hffff_ffff, 0);
        add_req(32'd7, 32'hffff_ffff, 0);
        for (int i = 0; i < 150; i++) begin
            mode = (pend_q.size() / 40) % 4;
            sel = $urandom_range(99);
            if (sel < 25) begin
                ka = pool_key();
                kb = pool_key();
            end else if (sel < 45) begin
                ka = pool_key();
                kb = $urandom;
            end else if (sel < 55) begin
                ka = ($urandom_range(1)) ? pool_key() : $urandom;
                kb = ka;
            end else if (sel < 70) begin
                ka = 37 + 1024 * $urandom_range(40);
                kb = ($urandom_range(1)) ? 37 + 1024 * $urandom_range(40) : pool_key();
            end else begin
                ka = $urandom;
                kb = $urandom;
            end
            if ($urandom_range(1)) add_req(ka, kb, mode);
            else add_req(kb, ka, mode);
        end
        // fill the store, then hit it with new and existing keys
        fill_i = 0;
        while (gen_keys.num() < MAX_ENT + 8) begin
            mode = (pend_q.size() / 40) % 4;
            add_req(32'h4000_0000 + 2 * fill_i, 32'h4000_0001 + 2 * fill_i, mode);
            fill_i++;
        end
        for (int i = 0; i < 12; i++) begin
            mode = (pend_q.size() / 40) % 4;
            add_req(pool_key(), pool_key(), mode);
            add_req(32'h6000_0000 + i, pool_key(), mode);
            add_req(32'h7000_0000 + i, 32'h7000_0000 + i, mode);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1;
        wait (pend_q.size() == 0 && !s_valid && swap_exp_q.size() == 0);
        repeat (500) @(posedge aclk);
        if (errors == 0 && swap_exp_q.size() == 0)
            $display("PASS sparse_identity_map_swap");
        else
            $display("FAIL sparse_identity_map_swap");
        $finish;
    end
endmodule
